// ----- hdl/khcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcs_pkg
// Shared types, constants and SHA-256 helper functions for the keyed hop
// channel selector.
// ----------------------------------------------------------------------------
package khcs_pkg;

   localparam int NUM_CHANNELS = 9;
   localparam int HOP_SHIFT    = 8;
   localparam int SEL_SHIFT    = HOP_SHIFT + 8;
   localparam int TBL_AW       = $clog2(NUM_CHANNELS);
   localparam int CNT_W        = 7;   // holds NUM_CHANNELS up to 127

   // selector remainder: one byte per cycle, quotient by reciprocal multiply
   localparam int SEL_XW    = CNT_W + 8;
   localparam int SEL_RSH   = 22;
   localparam int SEL_PW    = SEL_XW + SEL_RSH;
   localparam int SEL_RECIP = ((1 << SEL_RSH) + NUM_CHANNELS - 1) / NUM_CHANNELS;

   localparam logic [7:0] REG_KEY_UPPER = 8'd0;
   localparam logic [7:0] REG_KEY_LOWER = 8'd1;
   localparam logic [7:0] REG_IDENT     = 8'd2;
   localparam logic [7:0] REG_ON        = 8'd3;

   localparam logic [1:0] BLK_IPAD  = 2'd0;
   localparam logic [1:0] BLK_MSG   = 2'd1;
   localparam logic [1:0] BLK_OPAD  = 2'd2;
   localparam logic [1:0] BLK_OUTER = 2'd3;

   localparam logic [31:0] PAD_WORD     = 32'h8000_0000;
   localparam logic [31:0] LEN_DERIVE   = 32'd576;
   localparam logic [31:0] LEN_HOP      = 32'd544;
   localparam logic [31:0] LEN_OUTER    = 32'd768;
   localparam logic [31:0] HOP_MULT     = 32'd100;
   localparam logic [7:0]  IPAD_BYTE    = 8'h36;
   localparam logic [7:0]  OPAD_BYTE    = 8'h5c;

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef enum logic [1:0] {
      SHA_IDLE,
      SHA_RUN,
      SHA_FOLD
   } sha_state_type;

   typedef enum logic [3:0] {
      M_IDLE,
      M_INIT,
      M_HSTART,
      M_HWAIT,
      M_DIV,
      M_RDA,
      M_RDB,
      M_WRA,
      M_WRB,
      M_SELDIV,
      M_SELRD,
      M_SELWAIT,
      M_DONE
   } main_state_type;

   typedef struct packed {
      logic start;
      logic use_iv;
   } sha_ctl_type;

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ----- hdl/khcs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module khcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/khcs_sha_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khcs_sha_unit
// SHA-256 compression, one round per clock. Chaining value is kept inside;
// a start either restarts from the IV or continues from the last digest.
// ----------------------------------------------------------------------------
module khcs_sha_unit
   import khcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sha_ctl_type  ctl,
   input  logic [511:0] block,
   output logic         done,
   output logic [255:0] digest
);

   sha_state_type state_ff, state_in;
   logic [31:0]   hs_ff [8];
   logic [31:0]   hs_in [8];
   logic [31:0]   v_ff  [8];
   logic [31:0]   v_in  [8];
   logic [31:0]   w_ff  [16];
   logic [31:0]   w_in  [16];
   logic [5:0]    rnd_ff, rnd_in;
   logic          done_ff, done_in;

   logic [31:0] big_s1, big_s0, ch, mj, t1, t2, sm_s0, sm_s1, w_new;
   logic [255:0] base;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SHA_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      hs_ff  <= hs_in;
      v_ff   <= v_in;
      w_ff   <= w_in;
      rnd_ff <= rnd_in;
   end

   always_comb begin
      big_s1 = rotr32(v_ff[4], 6) ^ rotr32(v_ff[4], 11) ^ rotr32(v_ff[4], 25);
      ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big_s1 + ch + round_k(rnd_ff) + w_ff[0];
      big_s0 = rotr32(v_ff[0], 2) ^ rotr32(v_ff[0], 13) ^ rotr32(v_ff[0], 22);
      mj     = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big_s0 + mj;
      sm_s0  = rotr32(w_ff[1], 7) ^ rotr32(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sm_s1  = rotr32(w_ff[14], 17) ^ rotr32(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new  = w_ff[0] + sm_s0 + w_ff[9] + sm_s1;
      base   = ctl.use_iv ? SHA_IV : digest;

      state_in = state_ff;
      hs_in    = hs_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      rnd_in   = rnd_ff;
      done_in  = 1'b0;

      case (state_ff)
         SHA_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 8; i++) begin
                  hs_in[i] = base[255-32*i -: 32];
                  v_in[i]  = base[255-32*i -: 32];
               end
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = block[511-32*i -: 32];
               end
               rnd_in   = 6'd0;
               state_in = SHA_RUN;
            end
         end
         SHA_RUN: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = w_new;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = SHA_FOLD;
            end
         end
         SHA_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hs_in[i] = hs_ff[i] + v_ff[i];
            end
            done_in  = 1'b1;
            state_in = SHA_IDLE;
         end
         default: begin
            state_in = SHA_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[255-32*i -: 32] = hs_ff[i];
      end
   end

   assign done = done_ff;

endmodule

// ----- hdl/keyed_hop_channel_select_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_hop_channel_select_core
// Maps a nonce counter to a hop channel through an HMAC-SHA256 keyed
// Fisher-Yates shuffle of channels 1..N.
//
//   channel | dir | ports                          | handshake
//   req     | in  | req_nonce_count                | req_valid / req_stall
//   rsp     | out | rsp_channel, rsp_status        | rsp_valid / rsp_stall
//   csr     | in  | csr_index, csr_wdata           | csr_wr_en
//
// One item at a time. Each HMAC is four compressions on the single SHA
// round unit; after the table fill come N-1 hop HMACs, each with a
// bit-serial modulo and a swap, and then a bytewise selector remainder.
// The hop key is derived again after a register write. An inactive
// session skips all hashing and answers with status set.
// req_stall is high while an item is in work; reset is synchronous.
// ----------------------------------------------------------------------------
module keyed_hop_channel_select_core
   import khcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_nonce_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel,
   output logic        rsp_status,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   main_state_type state_ff, state_in;

   logic [63:0]  key_up_ff, key_lo_ff, ident_ff;
   logic         on_ff;
   logic [255:0] hk_ff, hk_in;
   logic         ready_ff, ready_in;
   logic [63:0]  nonce_ff, nonce_in;
   logic         kd_ff, kd_in;
   logic [1:0]   blk_ff, blk_in;
   logic [255:0] inner_ff, inner_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [TBL_AW-1:0] ini_ff, ini_in;
   logic [TBL_AW-1:0] pick_ff, pick_in;
   logic [7:0]   a_ff, a_in;
   logic [63:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [3:0]   res_ch_ff, res_ch_in;
   logic         res_st_ff, res_st_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   rsp_ch_ff, rsp_ch_in;
   logic         rsp_st_ff, rsp_st_in;

   sha_ctl_type  sha_ctl;
   logic [511:0] sha_block;
   logic         sha_done;
   logic [255:0] sha_digest;

   logic         ram_we;
   logic [TBL_AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]   ram_wdata, ram_rdata;

   logic [511:0] key_blk;
   logic [31:0]  hop_val;
   logic [CNT_W:0] trial;
   logic         cfg_hit;

   logic [SEL_XW-1:0] sel_x, sel_quo, sel_sub;
   logic [SEL_PW-1:0] sel_prod;

   khcs_sha_unit u_sha (
      .clock  (clock),
      .reset  (reset),
      .ctl    (sha_ctl),
      .block  (sha_block),
      .done   (sha_done),
      .digest (sha_digest)
   );

   khcs_ram #(
      .WIDTH (8),
      .DEPTH (NUM_CHANNELS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign cfg_hit = csr_wr_en && (csr_index == REG_KEY_UPPER || csr_index == REG_KEY_LOWER ||
                                  csr_index == REG_IDENT || csr_index == REG_ON);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= M_IDLE;
         key_up_ff    <= 64'd0;
         key_lo_ff    <= 64'd0;
         ident_ff     <= 64'd0;
         on_ff        <= 1'b0;
         hk_ff        <= 256'd0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hk_ff        <= hk_in;
         ready_ff     <= ready_in & ~cfg_hit;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_KEY_UPPER: key_up_ff <= csr_wdata;
               REG_KEY_LOWER: key_lo_ff <= csr_wdata;
               REG_IDENT:     ident_ff  <= csr_wdata;
               REG_ON:        on_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      nonce_ff  <= nonce_in;
      kd_ff     <= kd_in;
      blk_ff    <= blk_in;
      inner_ff  <= inner_in;
      n_ff      <= n_in;
      ini_ff    <= ini_in;
      pick_ff   <= pick_in;
      a_ff      <= a_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      cnt_ff    <= cnt_in;
      res_ch_ff <= res_ch_in;
      res_st_ff <= res_st_in;
      rsp_ch_ff <= rsp_ch_in;
      rsp_st_ff <= rsp_st_in;
   end

   // block source for the SHA unit
   always_comb begin
      key_blk = kd_ff ? {key_up_ff, key_lo_ff, 384'd0} : {hk_ff, 256'd0};
      hop_val = {24'd0, nonce_ff[HOP_SHIFT +: 8]} * HOP_MULT
              + {{(32-CNT_W){1'b0}}, n_ff};
      case (blk_ff)
         BLK_IPAD:  sha_block = key_blk ^ {64{IPAD_BYTE}};
         BLK_MSG:   sha_block = kd_ff ? {ident_ff, PAD_WORD, 384'd0, LEN_DERIVE}
                                      : {hop_val, PAD_WORD, 416'd0, LEN_HOP};
         BLK_OPAD:  sha_block = key_blk ^ {64{OPAD_BYTE}};
         BLK_OUTER: sha_block = {inner_ff, PAD_WORD, 192'd0, LEN_OUTER};
         default:   sha_block = 512'd0;
      endcase
   end

   // selector remainder step: previous remainder and next byte
   always_comb begin
      sel_x    = {rem_ff, dvd_ff[63:56]};
      sel_prod = SEL_PW'(sel_x) * SEL_PW'(SEL_RECIP);
      sel_quo  = sel_prod[SEL_RSH +: SEL_XW];
      sel_sub  = sel_x - SEL_XW'(sel_quo * SEL_XW'(NUM_CHANNELS));
   end

   always_comb begin
      trial = {rem_ff, dvd_ff[63]};

      state_in     = state_ff;
      hk_in        = hk_ff;
      ready_in     = ready_ff;
      nonce_in     = nonce_ff;
      kd_in        = kd_ff;
      blk_in       = blk_ff;
      inner_in     = inner_ff;
      n_in         = n_ff;
      ini_in       = ini_ff;
      pick_in      = pick_ff;
      a_in         = a_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      res_ch_in    = res_ch_ff;
      res_st_in    = res_st_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      sha_ctl      = '{start: 1'b0, use_iv: ~blk_ff[0]};
      ram_we       = 1'b0;
      ram_waddr    = ini_ff;
      ram_wdata    = 8'd0;
      ram_raddr    = pick_ff;

      // bit-serial remainder step for the swap index
      if (state_ff == M_DIV) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
      end

      case (state_ff)
         M_IDLE: begin
            if (req_valid) begin
               nonce_in = req_nonce_count;
               if (!on_ff) begin
                  res_ch_in = 4'd0;
                  res_st_in = 1'b1;
                  state_in  = M_DONE;
               end else begin
                  kd_in    = ~ready_ff;
                  blk_in   = BLK_IPAD;
                  ini_in   = '0;
                  state_in = M_INIT;
               end
            end
         end
         M_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = ini_ff;
            ram_wdata = 8'({1'b0, ini_ff} + 1'b1);
            ini_in    = ini_ff + 1'b1;
            if (ini_ff == TBL_AW'(NUM_CHANNELS - 1)) begin
               n_in     = CNT_W'(NUM_CHANNELS - 1);
               state_in = M_HSTART;
            end
         end
         M_HSTART: begin
            sha_ctl.start = 1'b1;
            state_in      = M_HWAIT;
         end
         M_HWAIT: begin
            if (sha_done) begin
               if (blk_ff != BLK_OUTER) begin
                  if (blk_ff == BLK_MSG) begin
                     inner_in = sha_digest;
                  end
                  blk_in   = blk_ff + 2'd1;
                  state_in = M_HSTART;
               end else begin
                  blk_in = BLK_IPAD;
                  if (kd_ff) begin
                     hk_in    = sha_digest;
                     ready_in = 1'b1;
                     kd_in    = 1'b0;
                     state_in = M_HSTART;
                  end else begin
                     dvd_in   = {32'd0, sha_digest[255:224]};
                     dvs_in   = n_ff + 1'b1;
                     rem_in   = '0;
                     cnt_in   = 6'd0;
                     state_in = M_DIV;
                  end
               end
            end
         end
         M_DIV: begin
            if (cnt_ff == 6'd63) begin
               pick_in  = TBL_AW'(rem_in);
               state_in = M_RDA;
            end
         end
         M_RDA: begin
            ram_raddr = n_ff[TBL_AW-1:0];
            state_in  = M_RDB;
         end
         M_RDB: begin
            ram_raddr = pick_ff;
            a_in      = ram_rdata;
            state_in  = M_WRA;
         end
         M_WRA: begin
            ram_we    = 1'b1;
            ram_waddr = n_ff[TBL_AW-1:0];
            ram_wdata = ram_rdata;
            state_in  = M_WRB;
         end
         M_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = pick_ff;
            ram_wdata = a_ff;
            if (n_ff == CNT_W'(1)) begin
               dvd_in   = nonce_ff >> SEL_SHIFT;
               rem_in   = '0;
               cnt_in   = 6'd0;
               state_in = M_SELDIV;
            end else begin
               n_in     = n_ff - 1'b1;
               state_in = M_HSTART;
            end
         end
         M_SELDIV: begin
            rem_in = sel_sub[CNT_W-1:0];
            dvd_in = {dvd_ff[55:0], 8'd0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd7) begin
               pick_in  = TBL_AW'(sel_sub);
               state_in = M_SELRD;
            end
         end
         M_SELRD: begin
            ram_raddr = pick_ff;
            state_in  = M_SELWAIT;
         end
         M_SELWAIT: begin
            res_ch_in = ram_rdata[3:0];
            res_st_in = 1'b0;
            state_in  = M_DONE;
         end
         M_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = res_ch_ff;
               rsp_st_in    = res_st_ff;
               state_in     = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   assign req_stall   = (state_ff != M_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_ch_ff;
   assign rsp_status  = rsp_st_ff;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyed_hop_channel_select_core. A local HMAC-SHA256
// hop-channel predictor runs on every accepted nonce. Each result is checked
// against the oldest prediction. Phases step through session off, extreme
// keys and random keys. Both sides idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import khcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 4000;
   localparam int DRAIN_CYCLES   = 3000;

   typedef struct packed {
      logic [3:0] channel;
      logic       status;
   } hop_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_nonce_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_channel;
   logic        rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   logic [63:0]  key_upper, key_lower, sess_ident;
   logic         sess_on;
   logic [63:0]  nonce_todo_q[$];
   hop_result_type chan_expect_q[$];
   int           errors = 0;
   int           idle_cycles = 0;
   int           send_gap = 0;
   int           stall_len = 0;
   int           hold_left = 0;
   bit           hold_req = 0;
   bit           quiet = 0;

   keyed_hop_channel_select_core uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] round_const(input int i);
      logic [31:0] k [64] = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [255:0] sha_block(input logic [255:0] h, input logic [511:0] b);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      logic [255:0] r;
      for (int t = 0; t < 16; t++) w[t] = b[511 - 32*t -: 32];
      for (int t = 16; t < 64; t++) begin
         s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int t = 0; t < 8; t++) v[t] = h[255 - 32*t -: 32];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(t) + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) r[255 - 32*t -: 32] = h[255 - 32*t -: 32] + v[t];
      return r;
   endfunction

   // key zero-padded to 64 bytes; msg_blk is the padded second inner block
   function automatic logic [255:0] hmac_sha(input logic [511:0] key_blk,
                                             input logic [511:0] msg_blk);
      logic [255:0] inner;
      logic [511:0] outer_blk;
      inner = sha_block(sha_block(SHA_IV, key_blk ^ {64{8'h36}}), msg_blk);
      outer_blk = '0;
      outer_blk[511:256] = inner;
      outer_blk[255:248] = 8'h80;
      outer_blk[63:0] = 64'd768;
      return sha_block(sha_block(SHA_IV, key_blk ^ {64{8'h5c}}), outer_blk);
   endfunction

   function automatic hop_result_type hop_channel_of(input logic [63:0] nonce);
      hop_result_type res;
      logic [511:0] blk;
      logic [255:0] hop_key, mac;
      logic [7:0]   perm [NUM_CHANNELS];
      logic [7:0]   tmp;
      logic [31:0]  hidx, m;
      res = '0;
      if (!sess_on) begin
         res.status = 1'b1;
         return res;
      end
      blk = '0;
      blk[511:448] = sess_ident;
      blk[447:440] = 8'h80;
      blk[63:0] = 64'd576;
      hop_key = hmac_sha({key_upper, key_lower, 384'b0}, blk);
      for (int n = 0; n < NUM_CHANNELS; n++) perm[n] = 8'(n + 1);
      hidx = 32'((nonce >> HOP_SHIFT) & 64'hFF);
      for (int n = NUM_CHANNELS - 1; n > 0; n--) begin
         blk = '0;
         blk[511:480] = hidx * 32'd100 + 32'(n);
         blk[479:472] = 8'h80;
         blk[63:0] = 64'd544;
         mac = hmac_sha({hop_key, 256'b0}, blk);
         m = mac[255:224] % 32'(n + 1);
         tmp = perm[n]; perm[n] = perm[m]; perm[m] = tmp;
      end
      res.channel = perm[(nonce >> SEL_SHIFT) % 64'(NUM_CHANNELS)][3:0];
      return res;
   endfunction

   function automatic int pick_gap();
      if (quiet || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) chan_expect_q.push_back(hop_channel_of(req_nonce_count));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (nonce_todo_q.size() > 0) begin
               req_valid <= 1'b1;
               req_nonce_count <= nonce_todo_q.pop_front();
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      hop_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (chan_expect_q.size() == 0) begin
               report_mismatch("unexpected item channel", int'(rsp_channel), -1);
            end else begin
               want = chan_expect_q.pop_front();
               if (rsp_channel !== want.channel)
                  report_mismatch("channel", rsp_channel, want.channel);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (hold_req) begin
            hold_req = 0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_len > 0) begin
            stall_len--;
            rsp_stall <= 1'b1;
         end else begin
            stall_len = pick_gap();
            rsp_stall <= (stall_len > 0);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(input logic [7:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_KEY_UPPER: key_upper = data;
         REG_KEY_LOWER: key_lower = data;
         REG_IDENT:     sess_ident = data;
         REG_ON:        sess_on = data[0];
         default: ;
      endcase
   endtask

   task automatic set_session(input logic [63:0] up, input logic [63:0] lo,
                              input logic [63:0] id, input logic [63:0] on_word);
      csr_write(REG_KEY_UPPER, up);
      csr_write(REG_KEY_LOWER, lo);
      csr_write(REG_IDENT, id);
      csr_write(REG_ON, on_word);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (nonce_todo_q.size() > 0 || req_valid || chan_expect_q.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_nonce();
      logic [63:0] x;
      x = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) x[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return x;
   endfunction

   initial begin
      key_upper = '0; key_lower = '0; sess_ident = '0; sess_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // session off after reset
      nonce_todo_q = '{64'h0, '1, 64'h0000_0000_0000_FF00, 64'hFFFF_FFFF_FFFF_00FF};
      wait_drained();

      // zero key; writes to unlisted indexes are ignored
      set_session('0, '0, '0, 64'd1);
      csr_write(8'd4, '1);
      csr_write(8'hFF, 64'h1234);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nonce_todo_q = '{64'h0, '1, 64'h0000_0000_0000_FF00, 64'hFFFF_FFFF_FFFF_00FF};
      for (int s = 0; s < NUM_CHANNELS; s++)
         nonce_todo_q.push_back((64'(s) << SEL_SHIFT) | (64'(s * 31) << HOP_SHIFT));
      wait_drained();

      // all-ones key and ident; on bit taken from bit 0 only
      set_session('1, '1, '1, '1);
      nonce_todo_q = '{64'h0, '1, 64'h0000_0000_0000_FF00, 64'h0000_0000_0008_0000};
      wait_drained();
      set_session('1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
      nonce_todo_q = '{64'h0, '1};
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         set_session({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     (ph == 4) ? 64'd0 : {$urandom, 31'h0, 1'b1});
         quiet = (ph == 2);
         for (int i = 0; i < 38; i++) nonce_todo_q.push_back(rand_nonce());
         if (ph == 1) hold_req = 1;
         wait_drained();
      end
      quiet = 0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chan_expect_q.size() != 0)
         report_mismatch("pending items", chan_expect_q.size(), 0);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/khcs_pkg.sv
hdl/khcs_ram.sv
hdl/khcs_sha_unit.sv
hdl/keyed_hop_channel_select_core.sv
dv/tb_top.sv
